>>> design/owbm_pkg.sv
`timescale 1ns / 1ps

package owbm_pkg;

	localparam int TIMER_WIDTH_DEF = 10;
	localparam int CFG_WIDTH       = 10;
	localparam int CFG_NUM         = 8;
	localparam int CFG_IDX_WIDTH   = $clog2(CFG_NUM);
	localparam int CMD_WIDTH       = 3;
	localparam int BYTE_WIDTH      = 8;
	localparam int BITS_WIDTH      = 4;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_RESET_LOW     = 3'd0,
		CFG_PRESENCE_WAIT = 3'd1,
		CFG_PRESENCE_TAIL = 3'd2,
		CFG_SLOT_LOW      = 3'd3,
		CFG_READ_SAMPLE   = 3'd4,
		CFG_READ_TAIL     = 3'd5,
		CFG_WRITE_HOLD    = 3'd6,
		CFG_RECOVERY      = 3'd7
	} cfg_idx_t;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_TICK       = 3'd0,
		CMD_RESET      = 3'd1,
		CMD_WRITE_BYTE = 3'd2,
		CMD_READ_BYTE  = 3'd3,
		CMD_WRITE_BIT  = 3'd4,
		CMD_READ_BIT   = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_SLOT_LOW = 3'd4,
		PH_SLOT_MID = 3'd5,
		PH_SLOT_END = 3'd6
	} phase_t;

	typedef logic [CFG_WIDTH-1:0] cfg_word_t;

	localparam cfg_word_t CFG_DEFAULTS [CFG_NUM] = '{
		10'd480, 10'd100, 10'd380, 10'd2, 10'd10, 10'd49, 10'd58, 10'd1
	};

	localparam logic [BITS_WIDTH-1:0] BITS_PER_BYTE = 4'd8;

endpackage

>>> design/one_wire_bus_master.sv
`timescale 1ns / 1ps

// 1-Wire bus master, one tick beat per clock when the output is ready: a beat
// carries the command and the sampled line level and yields exactly one result
// beat (drive enable/level, busy, done, presence, read value). The block sustains
// one beat per cycle unless the output side stalls; the tick beat is captured in
// an input register and its result is computed in one pass into the output
// register. Commands are honored only on a beat that finds the sequencer idle.
// The user must write timing registers through the cfg port only while no beat is
// in flight; the block does not enforce it. Durations count tick beats, not clocks.
module one_wire_bus_master #(
	parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [owbm_pkg::CMD_WIDTH-1:0]      command,
	input  logic [owbm_pkg::BYTE_WIDTH-1:0]     data_byte,
	input  logic                                line_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                drive_enable,
	output logic                                drive_level,
	output logic                                busy_res,
	output logic                                done_res,
	output logic                                presence,
	output logic [owbm_pkg::BYTE_WIDTH-1:0]     read_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [owbm_pkg::CFG_WIDTH-1:0]      cfg_data
);
	import owbm_pkg::*;

	typedef logic [TIMER_WIDTH-1:0] tmr_t;

	localparam tmr_t TMR_ONE = tmr_t'(1);

	cfg_word_t cfg_q [CFG_NUM];
	tmr_t      dur [CFG_NUM];

	// input register
	logic                  valid_s1;
	logic [CMD_WIDTH-1:0]  command_s1;
	logic [BYTE_WIDTH-1:0] data_s1;
	logic                  line_s1;

	// sequencer state
	phase_t                phase_q, phase_d;
	tmr_t                  timer_q, timer_d;
	logic [BITS_WIDTH-1:0] bits_q, bits_d;
	logic [BYTE_WIDTH-1:0] shift_q, shift_d;
	logic                  pres_q, pres_d;
	logic                  rd_q, rd_d;

	logic en_d, lvl_d, busy_d, done_d;
	logic advance;

	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				cfg_q[i] <= CFG_DEFAULTS[i];
			end
		end else if (cfg_valid) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// durations fitted to the timer width; zero counts as one tick
	always_comb begin
		for (int i = 0; i < CFG_NUM; i++) begin
			dur[i] = tmr_t'(cfg_q[i]);
			if (dur[i] == '0) begin
				dur[i] = TMR_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			data_s1    <= data_byte;
			line_s1    <= line_level;
		end
	end

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		rd_d    = rd_q;
		en_d    = 1'b0;
		lvl_d   = 1'b0;
		busy_d  = 1'b0;
		done_d  = 1'b0;

		if (phase_q == PH_IDLE) begin
			case (command_s1)
				CMD_RESET: begin
					phase_d = PH_RST_LOW;
					timer_d = dur[CFG_RESET_LOW];
				end
				CMD_WRITE_BYTE: begin
					rd_d    = 1'b0;
					shift_d = data_s1;
					bits_d  = BITS_PER_BYTE;
					phase_d = PH_SLOT_LOW;
					timer_d = dur[CFG_SLOT_LOW];
				end
				CMD_READ_BYTE: begin
					rd_d    = 1'b1;
					shift_d = '0;
					bits_d  = BITS_PER_BYTE;
					phase_d = PH_SLOT_LOW;
					timer_d = dur[CFG_SLOT_LOW];
				end
				CMD_WRITE_BIT: begin
					rd_d    = 1'b0;
					shift_d = {{(BYTE_WIDTH-1){1'b0}}, data_s1[0]};
					bits_d  = '0;
					phase_d = PH_SLOT_LOW;
					timer_d = dur[CFG_SLOT_LOW];
				end
				CMD_READ_BIT: begin
					rd_d    = 1'b1;
					shift_d = '0;
					bits_d  = '0;
					phase_d = PH_SLOT_LOW;
					timer_d = dur[CFG_SLOT_LOW];
				end
				default: begin
				end
			endcase
		end

		if (phase_d != PH_IDLE) begin
			busy_d = 1'b1;
			if (phase_d == PH_RST_LOW || phase_d == PH_SLOT_LOW) begin
				en_d = 1'b1;
			end else if (phase_d == PH_SLOT_MID && !rd_d) begin
				en_d  = 1'b1;
				lvl_d = shift_d[0];
			end

			if (timer_d > TMR_ONE) begin
				timer_d = timer_d - TMR_ONE;
			end else begin
				case (phase_d)
					PH_RST_LOW: begin
						phase_d = PH_RST_WAIT;
						timer_d = dur[CFG_PRESENCE_WAIT];
					end
					PH_RST_WAIT: begin
						pres_d  = !line_s1;
						phase_d = PH_RST_TAIL;
						timer_d = dur[CFG_PRESENCE_TAIL];
					end
					PH_RST_TAIL: begin
						phase_d = PH_IDLE;
						timer_d = '0;
						done_d  = 1'b1;
					end
					PH_SLOT_LOW: begin
						phase_d = PH_SLOT_MID;
						timer_d = rd_d ? dur[CFG_READ_SAMPLE] : dur[CFG_WRITE_HOLD];
					end
					PH_SLOT_MID: begin
						if (rd_d) begin
							if (bits_d == '0) begin
								shift_d = {{(BYTE_WIDTH-1){1'b0}}, line_s1};
							end else begin
								shift_d = {line_s1, shift_d[BYTE_WIDTH-1:1]};
							end
						end
						phase_d = PH_SLOT_END;
						timer_d = rd_d ? dur[CFG_READ_TAIL] : dur[CFG_RECOVERY];
					end
					default: begin
						if (!rd_d) begin
							shift_d = {1'b0, shift_d[BYTE_WIDTH-1:1]};
						end
						if (bits_d <= 4'd1 || phase_d != PH_SLOT_END) begin
							bits_d  = '0;
							phase_d = PH_IDLE;
							timer_d = '0;
							done_d  = 1'b1;
						end else begin
							bits_d  = bits_d - 4'd1;
							phase_d = PH_SLOT_LOW;
							timer_d = dur[CFG_SLOT_LOW];
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			rd_q    <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			rd_q    <= rd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_enable <= en_d;
			drive_level  <= lvl_d;
			busy_res     <= busy_d;
			done_res     <= done_d;
			presence     <= pres_d;
			read_value   <= rd_d ? shift_d : '0;
		end
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	a_lvl_en: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_level |-> drive_enable)
		else $error("drive level high while released");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> timer_q == '0)
		else $error("timer running while idle");

	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BITS_PER_BYTE)
		else $error("bit count out of range");

	a_write_rv: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance) && !rd_q |-> read_value == '0)
		else $error("read value nonzero after write");

endmodule

>>> test/one_wire_checker.sv
`timescale 1ns / 1ps

module one_wire_checker #(
	parameter int TIMER_WIDTH = owbm_pkg::TIMER_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [owbm_pkg::CMD_WIDTH-1:0]      command,
	input  logic [owbm_pkg::BYTE_WIDTH-1:0]     data_byte,
	input  logic                                line_level,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                drive_enable,
	input  logic                                drive_level,
	input  logic                                busy_res,
	input  logic                                done_res,
	input  logic                                presence,
	input  logic [owbm_pkg::BYTE_WIDTH-1:0]     read_value,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [owbm_pkg::CFG_WIDTH-1:0]      cfg_data,
	output int                                  errors,
	output int                                  pending,
	output logic                                seq_idle
);

	import owbm_pkg::*;

	typedef struct packed {
		logic                  en;
		logic                  lvl;
		logic                  busy;
		logic                  done;
		logic                  pres;
		logic [BYTE_WIDTH-1:0] rd;
	} bus_view_t;

	cfg_word_t             timing [CFG_NUM];
	phase_t                phase;
	int unsigned           ticks_left;
	logic [BITS_WIDTH-1:0] bits_left;
	logic [BYTE_WIDTH-1:0] shreg;
	logic                  pres_flag;
	logic                  rd_op;
	bus_view_t             bus_view_q [$];

	// durations are cut to the timer width; zero behaves as one tick
	function automatic int unsigned span(cfg_idx_t idx);
		int unsigned d;
		d = timing[idx] & ((1 << TIMER_WIDTH) - 1);
		return (d == 0) ? 1 : d;
	endfunction

	task automatic open_slots(input logic rd, input logic [BYTE_WIDTH-1:0] sr,
			input logic [BITS_WIDTH-1:0] n);
		rd_op = rd;
		shreg = sr;
		bits_left = n;
		phase = PH_SLOT_LOW;
		ticks_left = span(CFG_SLOT_LOW);
	endtask

	task automatic advance_bus(input logic [CMD_WIDTH-1:0] cmd,
			input logic [BYTE_WIDTH-1:0] data, input logic line, output bus_view_t r);
		r = '0;
		if (phase == PH_IDLE) begin
			case (cmd)
				CMD_RESET: begin
					phase = PH_RST_LOW;
					ticks_left = span(CFG_RESET_LOW);
				end
				CMD_WRITE_BYTE: open_slots(1'b0, data, BITS_PER_BYTE);
				CMD_READ_BYTE:  open_slots(1'b1, '0, BITS_PER_BYTE);
				CMD_WRITE_BIT:  open_slots(1'b0, {{(BYTE_WIDTH-1){1'b0}}, data[0]}, '0);
				CMD_READ_BIT:   open_slots(1'b1, '0, '0);
				default: ;
			endcase
		end
		if (phase != PH_IDLE) begin
			r.busy = 1'b1;
			if (phase == PH_RST_LOW || phase == PH_SLOT_LOW) begin
				r.en = 1'b1;
			end else if (phase == PH_SLOT_MID && !rd_op) begin
				r.en = 1'b1;
				r.lvl = shreg[0];
			end
			if (ticks_left > 1) begin
				ticks_left--;
			end else begin
				case (phase)
					PH_RST_LOW: begin
						phase = PH_RST_WAIT;
						ticks_left = span(CFG_PRESENCE_WAIT);
					end
					PH_RST_WAIT: begin
						pres_flag = ~line;
						phase = PH_RST_TAIL;
						ticks_left = span(CFG_PRESENCE_TAIL);
					end
					PH_RST_TAIL: begin
						phase = PH_IDLE;
						ticks_left = 0;
						r.done = 1'b1;
					end
					PH_SLOT_LOW: begin
						phase = PH_SLOT_MID;
						if (rd_op)
							ticks_left = span(CFG_READ_SAMPLE);
						else
							ticks_left = span(CFG_WRITE_HOLD);
					end
					PH_SLOT_MID: begin
						// single read bit lands in bit 0, byte reads shift in from the top
						if (rd_op)
							shreg = (bits_left == 0) ? {{(BYTE_WIDTH-1){1'b0}}, line}
								: {line, shreg[BYTE_WIDTH-1:1]};
						phase = PH_SLOT_END;
						if (rd_op)
							ticks_left = span(CFG_READ_TAIL);
						else
							ticks_left = span(CFG_RECOVERY);
					end
					default: begin
						if (!rd_op)
							shreg = shreg >> 1;
						if (bits_left <= 1) begin
							bits_left = '0;
							phase = PH_IDLE;
							ticks_left = 0;
							r.done = 1'b1;
						end else begin
							bits_left--;
							phase = PH_SLOT_LOW;
							ticks_left = span(CFG_SLOT_LOW);
						end
					end
				endcase
			end
		end
		r.pres = pres_flag;
		r.rd = rd_op ? shreg : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		bus_view_t want;
		bus_view_t got;
		bus_view_t next_view;
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++)
				timing[i] = CFG_DEFAULTS[i];
			phase = PH_IDLE;
			ticks_left = 0;
			bits_left = '0;
			shreg = '0;
			pres_flag = 1'b0;
			rd_op = 1'b0;
			bus_view_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {drive_enable, drive_level, busy_res, done_res, presence, read_value};
				if (bus_view_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with none expected: en=%b lvl=%b busy=%b done=%b pres=%b rd=%h",
						$time, got.en, got.lvl, got.busy, got.done, got.pres, got.rd);
				end else begin
					want = bus_view_q.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected en=%b lvl=%b busy=%b done=%b pres=%b rd=%h",
							$time, want.en, want.lvl, want.busy, want.done, want.pres, want.rd);
						$display("%0t:          actual en=%b lvl=%b busy=%b done=%b pres=%b rd=%h",
							$time, got.en, got.lvl, got.busy, got.done, got.pres, got.rd);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				timing[cfg_index] = cfg_data;
			if (in_valid && in_ready) begin
				advance_bus(command, data_byte, line_level, next_view);
				bus_view_q.push_back(next_view);
			end
		end
		pending = bus_view_q.size();
		seq_idle = (phase == PH_IDLE);
	end

endmodule

>>> test/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps

module one_wire_bus_master_tb;

	import owbm_pkg::*;

	localparam logic [CMD_WIDTH-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_WIDTH-1:0] CMD_RSVD_7 = 3'd7;
	localparam int TIMING_MIN = 1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_WIDTH-1:0]     command = '0;
	logic [BYTE_WIDTH-1:0]    data_byte = '0;
	logic                     line_level = 1'b1;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     drive_enable;
	logic                     drive_level;
	logic                     busy_res;
	logic                     done_res;
	logic                     presence;
	logic [BYTE_WIDTH-1:0]    read_value;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]     cfg_data = '0;

	int        errors;
	int        pending;
	logic      seq_idle;
	bit        quiet = 1'b0;
	bit        hold_request = 1'b0;
	cfg_word_t timing [CFG_NUM];

	always #10 clk = ~clk;

	one_wire_bus_master DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.data_byte    (data_byte),
		.line_level   (line_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_enable (drive_enable),
		.drive_level  (drive_level),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.presence     (presence),
		.read_value   (read_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	one_wire_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.data_byte    (data_byte),
		.line_level   (line_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_enable (drive_enable),
		.drive_level  (drive_level),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.presence     (presence),
		.read_value   (read_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.seq_idle     (seq_idle)
	);

	task automatic send_tick(input logic [CMD_WIDTH-1:0] cmd, input logic [BYTE_WIDTH-1:0] data,
			input logic line);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= data;
		line_level <= line;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// tick the running sequence out (commands sent meanwhile are ignored), then drain
	task automatic settle(input bit pin, input logic lvl);
		logic [CMD_WIDTH-1:0] c;
		logic                 l;
		while (!seq_idle) begin
			c = 3'($urandom_range(0, 7));
			l = pin ? lvl : 1'($urandom_range(0, 1));
			send_tick(c, 8'($urandom_range(0, 255)), l);
		end
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic program_timing(input int lo, input int hi);
		for (int i = 0; i < CFG_NUM; i++) begin
			timing[i] = cfg_word_t'($urandom_range(lo, hi));
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= timing[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n);
		logic [CMD_WIDTH-1:0] c;
		repeat (n) begin
			c = $urandom_range(0, 1) ? CMD_TICK : 3'($urandom_range(1, 7));
			send_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		settle(1'b0, 1'b0);
	endtask

	// result side: random stalls, plus one long hold on request
	initial begin : sink
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				hold_request = 1'b0;
				repeat (120) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset-time timing values
		send_tick(CMD_WRITE_BIT, 8'h01, 1'b1);
		settle(1'b0, 1'b0);
		send_tick(CMD_READ_BIT, 8'h00, 1'b1);
		settle(1'b1, 1'b1);

		// shortest slots: byte extremes, presence both ways, write clears read value
		program_timing(TIMING_MIN, TIMING_MIN);
		send_tick(CMD_RSVD_6, 8'hFF, 1'b0);
		send_tick(CMD_RSVD_7, 8'h00, 1'b1);
		send_tick(CMD_TICK, 8'hFF, 1'b0);
		send_tick(CMD_WRITE_BYTE, 8'hFF, 1'b0);
		settle(1'b0, 1'b0);
		send_tick(CMD_WRITE_BYTE, 8'h00, 1'b1);
		settle(1'b1, 1'b1);
		send_tick(CMD_READ_BYTE, 8'h00, 1'b1);
		settle(1'b1, 1'b1);
		send_tick(CMD_READ_BYTE, 8'hFF, 1'b0);
		settle(1'b1, 1'b0);
		send_tick(CMD_RESET, 8'h00, 1'b1);
		settle(1'b1, 1'b1);
		send_tick(CMD_READ_BIT, 8'h00, 1'b1);
		settle(1'b1, 1'b1);
		send_tick(CMD_WRITE_BIT, 8'hFE, 1'b0);
		settle(1'b0, 1'b0);
		send_tick(CMD_RESET, 8'hFF, 1'b0);
		settle(1'b1, 1'b0);

		for (int p = 0; p < 5; p++) begin
			program_timing(TIMING_MIN, 3 * p + 3);
			if (p == 2)
				hold_request = 1'b1;
			run_random(50);
		end

		program_timing(TIMING_MIN, 4);
		quiet = 1'b1;
		run_random(60);

		repeat (10) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
